@@ design/fsmc_pkg.sv @@
// Shared types, opcodes and status codes for the Forth stack machine core.
package fsmc_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int WORD_W          = 32;
    localparam int DIV_STEPS       = WORD_W;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

    typedef enum logic [4:0] {
        OP_LIT    = 5'd0,
        OP_ADD    = 5'd1,
        OP_SUB    = 5'd2,
        OP_MUL    = 5'd3,
        OP_DIV    = 5'd4,
        OP_MOD    = 5'd5,
        OP_EQ     = 5'd6,
        OP_LT     = 5'd7,
        OP_GT     = 5'd8,
        OP_DUP    = 5'd9,
        OP_DROP   = 5'd10,
        OP_SWAP   = 5'd11,
        OP_OVER   = 5'd12,
        OP_ROT    = 5'd13,
        OP_PRINT  = 5'd14,
        OP_EMIT   = 5'd15,
        OP_TO_R   = 5'd16,
        OP_R_FROM = 5'd17,
        OP_R_FET  = 5'd18,
        OP_INDEX  = 5'd19,
        OP_CR     = 5'd20
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    localparam logic [WORD_W-1:0] TRUE_WORD = '1;
    localparam logic [WORD_W-1:0] NEWLINE   = WORD_W'(10);

    typedef struct packed {
        logic [4:0]               cmd;
        logic signed [WORD_W-1:0] literal;
    } in_item_t;

    typedef struct packed {
        logic                     out_valid;
        logic                     out_kind;
        logic signed [WORD_W-1:0] out_value;
        logic [2:0]               status;
        logic [7:0]               data_depth;
        logic signed [WORD_W-1:0] top_value;
        logic [7:0]               return_depth;
    } res_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
        logic div_start;
        logic rot2;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
        logic rot_ok;
    } stat_t;

endpackage

@@ design/fsmc_div.sv @@
// Iterative restoring divider on 32-bit magnitudes, one quotient bit per cycle.
module fsmc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsmc_pkg::WORD_W-1:0] dividend,
    input  logic [fsmc_pkg::WORD_W-1:0] divisor,
    output logic [fsmc_pkg::WORD_W-1:0] quot,
    output logic [fsmc_pkg::WORD_W-1:0] rem,
    output logic                        done
);
    localparam int W = fsmc_pkg::WORD_W;

    logic [fsmc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [W-1:0]                   quo_reg, quo_next;
    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   dvs_reg, dvs_next;
    logic [W:0]                     shifted;
    logic                           ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[W-1]};
        ge        = shifted >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? W'(shifted - {1'b0, dvs_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fsmc_pkg::DIV_CNT_W'(fsmc_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

@@ design/fsmc_ctrl.sv @@
// Sequencing state machine: accept, execute, divide wait, second rot write.
module fsmc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fsmc_pkg::stat_t stat,
    output fsmc_pkg::ctl_t  ctl
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DIVW = 5'b00100,
        S_DFIN = 5'b01000,
        S_ROT2 = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   fin;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        fin           = 1'b0;
        ctl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
                else
                    fin = 1'b1;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                    state_next = S_DFIN;
            end
            S_DFIN:
                fin = 1'b1;
            S_ROT2:
            begin
                ctl.rot2   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // hold until the result slot is free
        if (fin && stat.out_free)
        begin
            ctl.commit = 1'b1;
            state_next = stat.rot_ok ? S_ROT2 : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/fsmc_dpath.sv @@
// Datapath: stack memories, cached top of stack, ALU, divider and result register.
module fsmc_dpath #(
    parameter int STACK_DEPTH = fsmc_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsmc_pkg::in_item_t   in_item,
    input  fsmc_pkg::ctl_t       ctl,
    output fsmc_pkg::stat_t      stat,
    output logic                 res_valid,
    input  logic                 res_ready,
    output fsmc_pkg::res_item_t  res_data
);
    localparam int W  = fsmc_pkg::WORD_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);
    localparam logic [PW-1:0] ONE     = PW'(1);
    localparam logic [PW-1:0] TWO     = PW'(2);
    localparam logic [PW-1:0] THREE   = PW'(3);

    // data memory holds every entry below the top; the top lives in tos_reg
    logic [W-1:0] dmem [STACK_DEPTH];
    logic [W-1:0] rmem [STACK_DEPTH];

    logic [PW-1:0] dp_reg, dp_next, rp_reg, rp_next;
    logic [W-1:0]  tos_reg, tos_next;
    logic [W-1:0]  sec_q, thd_q, r1_q, r2_q;
    logic [4:0]    cmd_reg;
    logic [W-1:0]  lit_reg, rot_c_reg;
    logic          out_full_reg;
    fsmc_pkg::res_item_t out_reg, out_next;

    logic [PW-1:0] dpm1, dpm2, dpm3, rpm1, rpm2, dpp;
    logic          has1, has2, has3, full, r_full;
    logic [W-1:0]  a_op, b_op, ua, ub, quot, rem, alu;
    logic          div_done, divz;
    logic          d_we, r_we;
    logic [AW-1:0] d_waddr, r_waddr;
    logic [W-1:0]  d_wdata, r_wdata;
    logic          push_en;
    logic [W-1:0]  push_v;
    fsmc_pkg::status_t st;
    logic          ov, ok;
    logic [W-1:0]  val;
    logic [PW+7:0] dp_ext, rp_ext;

    assign dpm1   = dp_reg - ONE;
    assign dpm2   = dp_reg - TWO;
    assign dpm3   = dp_reg - THREE;
    assign rpm1   = rp_reg - ONE;
    assign rpm2   = rp_reg - TWO;
    assign has1   = dp_reg != '0;
    assign has2   = dp_reg >= TWO;
    assign has3   = dp_reg >= THREE;
    assign full   = dp_reg >= DEPTH_P;
    assign r_full = rp_reg >= DEPTH_P;
    assign b_op   = has1 ? tos_reg : '0;
    assign a_op   = has2 ? sec_q : '0;
    assign dpp    = has2 ? dpm2 : '0;
    assign divz   = b_op == '0;
    assign ua     = a_op[W-1] ? W'(-a_op) : a_op;
    assign ub     = b_op[W-1] ? W'(-b_op) : b_op;

    fsmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (ua),
        .divisor  (ub),
        .quot     (quot),
        .rem      (rem),
        .done     (div_done)
    );

    always_comb
    begin
        unique case (cmd_reg)
            fsmc_pkg::OP_ADD: alu = a_op + b_op;
            fsmc_pkg::OP_SUB: alu = a_op - b_op;
            fsmc_pkg::OP_MUL: alu = W'(a_op * b_op);
            fsmc_pkg::OP_DIV:
                alu = divz ? a_op : ((a_op[W-1] ^ b_op[W-1]) ? W'(-quot) : quot);
            fsmc_pkg::OP_MOD:
                alu = divz ? a_op : (a_op[W-1] ? W'(-rem) : rem);
            fsmc_pkg::OP_EQ:
                alu = (a_op == b_op) ? fsmc_pkg::TRUE_WORD : '0;
            fsmc_pkg::OP_LT:
                alu = ($signed(a_op) < $signed(b_op)) ? fsmc_pkg::TRUE_WORD : '0;
            fsmc_pkg::OP_GT:
                alu = ($signed(b_op) < $signed(a_op)) ? fsmc_pkg::TRUE_WORD : '0;
            default: alu = '0;
        endcase
    end

    always_comb
    begin
        dp_next  = dp_reg;
        tos_next = tos_reg;
        rp_next  = rp_reg;
        d_we     = 1'b0;
        d_waddr  = dpm1[AW-1:0];
        d_wdata  = tos_reg;
        r_we     = 1'b0;
        r_waddr  = rp_reg[AW-1:0];
        r_wdata  = b_op;
        st       = fsmc_pkg::ST_OK;
        ov       = 1'b0;
        ok       = 1'b0;
        val      = '0;
        push_en  = 1'b0;
        push_v   = '0;
        unique case (cmd_reg)
            fsmc_pkg::OP_LIT:
            begin
                push_en = 1'b1;
                push_v  = lit_reg;
            end
            fsmc_pkg::OP_ADD, fsmc_pkg::OP_SUB, fsmc_pkg::OP_MUL, fsmc_pkg::OP_DIV,
            fsmc_pkg::OP_MOD, fsmc_pkg::OP_EQ, fsmc_pkg::OP_LT, fsmc_pkg::OP_GT:
            begin
                // pop two, push one: the slot below stays in memory
                dp_next  = dpp + ONE;
                tos_next = alu;
                if (!has2)
                    st = fsmc_pkg::ST_UNDER;
                else if (divz && (cmd_reg == fsmc_pkg::OP_DIV ||
                                  cmd_reg == fsmc_pkg::OP_MOD))
                    st = fsmc_pkg::ST_DIVZ;
            end
            fsmc_pkg::OP_DUP:
            begin
                if (has1)
                begin
                    push_en = 1'b1;
                    push_v  = tos_reg;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
            end
            fsmc_pkg::OP_OVER:
            begin
                if (has2)
                begin
                    push_en = 1'b1;
                    push_v  = sec_q;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
            end
            fsmc_pkg::OP_DROP:
            begin
                if (has1)
                begin
                    tos_next = sec_q;
                    dp_next  = dpm1;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
            end
            fsmc_pkg::OP_SWAP:
            begin
                if (has2)
                begin
                    d_we     = 1'b1;
                    d_waddr  = dpm2[AW-1:0];
                    d_wdata  = tos_reg;
                    tos_next = sec_q;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
            end
            fsmc_pkg::OP_ROT:
            begin
                // third goes on top; second moves down now, old top next cycle
                if (has3)
                begin
                    d_we     = 1'b1;
                    d_waddr  = dpm3[AW-1:0];
                    d_wdata  = sec_q;
                    tos_next = thd_q;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
            end
            fsmc_pkg::OP_PRINT, fsmc_pkg::OP_EMIT:
            begin
                if (has1)
                begin
                    ov       = 1'b1;
                    ok       = cmd_reg == fsmc_pkg::OP_EMIT;
                    val      = ok ? {{(W-8){1'b0}}, tos_reg[7:0]} : tos_reg;
                    tos_next = sec_q;
                    dp_next  = dpm1;
                end
                else
                    st = fsmc_pkg::ST_EMPTY;
            end
            fsmc_pkg::OP_TO_R:
            begin
                if (has1)
                begin
                    tos_next = sec_q;
                    dp_next  = dpm1;
                end
                else
                    st = fsmc_pkg::ST_UNDER;
                if (!r_full)
                begin
                    r_we    = 1'b1;
                    rp_next = rp_reg + ONE;
                end
            end
            fsmc_pkg::OP_R_FROM:
            begin
                push_en = 1'b1;
                push_v  = (rp_reg != '0) ? r1_q : '0;
                if (rp_reg != '0)
                    rp_next = rpm1;
            end
            fsmc_pkg::OP_R_FET:
            begin
                push_en = rp_reg >= ONE;
                push_v  = r1_q;
            end
            fsmc_pkg::OP_INDEX:
            begin
                push_en = rp_reg >= TWO;
                push_v  = r2_q;
            end
            fsmc_pkg::OP_CR:
            begin
                ov  = 1'b1;
                ok  = 1'b1;
                val = fsmc_pkg::NEWLINE;
            end
            default: ;
        endcase

        if (push_en)
        begin
            if (!full)
            begin
                d_we     = has1;
                d_waddr  = dpm1[AW-1:0];
                d_wdata  = tos_reg;
                tos_next = push_v;
                dp_next  = dp_reg + ONE;
            end
            else if (st == fsmc_pkg::ST_OK)
                st = fsmc_pkg::ST_OVER;
        end

        if (ctl.rot2)
        begin
            d_we    = 1'b1;
            d_waddr = dpm2[AW-1:0];
            d_wdata = rot_c_reg;
        end
    end

    assign dp_ext = {8'b0, dp_next};
    assign rp_ext = {8'b0, rp_next};

    always_comb
    begin
        out_next.out_valid    = ov;
        out_next.out_kind     = ok;
        out_next.out_value    = val;
        out_next.status       = st;
        out_next.data_depth   = dp_ext[7:0];
        out_next.top_value    = (dp_next != '0) ? tos_next : '0;
        out_next.return_depth = rp_ext[7:0];
    end

    always_ff @(posedge clk)
    begin
        sec_q <= dmem[dpm2[AW-1:0]];
        thd_q <= dmem[dpm3[AW-1:0]];
        r1_q  <= rmem[rpm1[AW-1:0]];
        r2_q  <= rmem[rpm2[AW-1:0]];
        if ((ctl.commit || ctl.rot2) && d_we)
            dmem[d_waddr] <= d_wdata;
        if (ctl.commit && r_we)
            rmem[r_waddr] <= r_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= in_item.cmd;
            lit_reg <= in_item.literal;
        end
        if (ctl.commit)
        begin
            tos_reg   <= tos_next;
            rot_c_reg <= tos_reg;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg       <= '0;
            rp_reg       <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (ctl.commit)
            begin
                dp_reg       <= dp_next;
                rp_reg       <= rp_next;
                out_full_reg <= 1'b1;
            end
            else if (res_ready)
                out_full_reg <= 1'b0;
        end
    end

    assign stat.need_div = (cmd_reg == fsmc_pkg::OP_DIV || cmd_reg == fsmc_pkg::OP_MOD)
                           && !divz;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_full_reg || res_ready;
    assign stat.rot_ok   = (cmd_reg == fsmc_pkg::OP_ROT) && has3;

    assign res_valid = out_full_reg;
    assign res_data  = out_reg;

endmodule

@@ design/forth_stack_machine_core.sv @@
// Top level: Forth stack machine core with data and return stacks.
// Sequencing: an accepted item executes and commits to the registered result slot; rot adds
// a second write state before the next input; div and mod wait on the 32-step divider, except on a zero divisor.
// Items are taken one at a time: no new input until the previous one commits, which waits for a free result slot.
// Reset: rst_n clears both stack pointers, the state machine and the result slot;
// stack contents are left as they are and only read below the pointers.
module forth_stack_machine_core #(
    parameter int STACK_DEPTH = fsmc_pkg::STACK_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsmc_pkg::in_item_t  in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output fsmc_pkg::res_item_t res_data
);

    fsmc_pkg::ctl_t  ctl;
    fsmc_pkg::stat_t stat;

    // Controller: one item at a time; the result register lets a new
    // transfer come in while the previous result still waits downstream.
    fsmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath: stack memories with a cached top, ALU, divider, result slot.
    fsmc_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // A transfer in is followed by execution: the input is not ready in the cycle after it.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken in consecutive cycles");

    // Printed output never carries a fault.
    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.out_valid) |-> (res_data.status == fsmc_pkg::ST_OK))
        else $error("printed item with fault status");

    // A commit only happens when the result slot can take it.
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (!res_valid || res_ready))
        else $error("result overwritten before transfer");

    // The second rot write follows its commit directly.
    a_rot_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rot2 |-> $past(ctl.commit))
        else $error("rot write without commit");

endmodule
